// File: rtl/sdpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdpe_pkg;

   localparam int COORD_W = 12;
   localparam int COUNT_W = 12;
   localparam int WORD_W = 16;
   localparam int KIND_W = 3;
   localparam int THR_W = 8;
   localparam logic [THR_W-1:0] THR_RESET = 8'hE0;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 12'hFFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   // result kinds
   localparam logic [KIND_W-1:0] KIND_TRAVEL = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ROW = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DOT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ROW_END = 3'd4;

   // word prefixes
   localparam logic [3:0] ROW_PREFIX = 4'h8;
   localparam logic [3:0] DOT_PREFIX = 4'h7;

   // result slots in emission order
   localparam int SLOT_TRAV1 = 0;
   localparam int SLOT_ROW = 1;
   localparam int SLOT_TRAV2 = 2;
   localparam int SLOT_EMPTY = 3;
   localparam int SLOT_DOT = 4;
   localparam int SLOT_END = 5;
   localparam int NUM_SLOTS = 6;

   localparam logic [NUM_SLOTS-1:0] SEL_TRAV1 = 6'b000001;
   localparam logic [NUM_SLOTS-1:0] SEL_ROW = 6'b000010;
   localparam logic [NUM_SLOTS-1:0] SEL_TRAV2 = 6'b000100;
   localparam logic [NUM_SLOTS-1:0] SEL_EMPTY = 6'b001000;
   localparam logic [NUM_SLOTS-1:0] SEL_DOT = 6'b010000;
   localparam logic [NUM_SLOTS-1:0] SEL_END = 6'b100000;

   // all results caused by one pixel
   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      logic rev;
      logic [COORD_W-1:0] t1_start;
      logic [COORD_W-1:0] last_col;
      logic [COUNT_W-1:0] trav_count;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] e_start;
      logic [COUNT_W-1:0] e_count;
      logic [COORD_W-1:0] dot_col;
      logic end_desc;
   } bundle_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] word;
      logic [COUNT_W-1:0] count;
      logic desc;
      logic last;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/sdpe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sdpe_front #(
   parameter int COORD_BITS = 12
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire [sdpe_pkg::THR_W-1:0]     threshold,
   input  wire                           in_valid,
   output logic                          in_ready,
   input  wire [7:0]                     pixel,
   input  wire [sdpe_pkg::COORD_W-1:0]   column,
   input  wire [sdpe_pkg::COORD_W-1:0]   row,
   input  wire                           end_of_row,
   input  wire                           q_full,
   output logic                          push_valid,
   output sdpe_pkg::bundle_type          push_data
);

   logic                    rev_ff, rev_in;
   logic                    row_dot_ff, row_dot_in;
   logic                    any_dot_ff, any_dot_in;
   logic [COORD_BITS-1:0]   last_col_ff, last_col_in;
   logic [COORD_BITS-1:0]   e_start_ff, e_start_in;
   logic [sdpe_pkg::COUNT_W-1:0] e_len_ff, e_len_in;

   logic                    accept;
   logic                    is_dot;
   logic [COORD_BITS-1:0]   col_c;
   logic [COORD_BITS-1:0]   row_c;
   logic [COORD_BITS:0]     diff;
   logic [COORD_BITS:0]     neg_diff;
   logic                    back_pos;
   logic                    back_neg;
   logic [COORD_BITS-1:0]   mag;
   logic [COORD_BITS-1:0]   t1_start;
   logic                    row_dot_next;

   assign in_ready = !q_full;
   assign accept = in_valid && in_ready;
   assign is_dot = pixel >= threshold;
   assign col_c = column[COORD_BITS-1:0];
   assign row_c = row[COORD_BITS-1:0];

   // back distance: positive means the new dot lies behind the last one
   assign diff = rev_ff ? ({1'b0, col_c} - {1'b0, last_col_ff})
                        : ({1'b0, last_col_ff} - {1'b0, col_c});
   assign neg_diff = -diff;
   assign back_neg = diff[COORD_BITS];
   assign back_pos = !diff[COORD_BITS] && (diff != '0);
   assign mag = back_neg ? neg_diff[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
   assign t1_start = rev_ff ? (last_col_ff + 1'b1) : (last_col_ff - 1'b1);
   assign row_dot_next = is_dot || row_dot_ff;

   always_comb begin
      push_data = '0;
      push_data.rev = rev_ff;
      push_data.t1_start = sdpe_pkg::COORD_W'(t1_start);
      push_data.last_col = sdpe_pkg::COORD_W'(last_col_ff);
      push_data.trav_count = sdpe_pkg::COUNT_W'(mag);
      push_data.row = sdpe_pkg::COORD_W'(row_c);
      push_data.e_start = sdpe_pkg::COORD_W'(e_start_ff);
      push_data.e_count = e_len_ff;
      push_data.dot_col = sdpe_pkg::COORD_W'(col_c);
      push_data.end_desc = rev_ff ^ row_dot_next;
      if (is_dot) begin
         push_data.mask[sdpe_pkg::SLOT_DOT] = 1'b1;
         if (!row_dot_ff) begin
            push_data.mask[sdpe_pkg::SLOT_TRAV1] = back_pos;
            push_data.mask[sdpe_pkg::SLOT_ROW] = 1'b1;
            push_data.mask[sdpe_pkg::SLOT_TRAV2] = back_neg && any_dot_ff;
         end else begin
            push_data.mask[sdpe_pkg::SLOT_EMPTY] = e_len_ff != '0;
         end
      end
      push_data.mask[sdpe_pkg::SLOT_END] = end_of_row;
   end

   assign push_valid = accept && (push_data.mask != '0);

   always_comb begin
      rev_in = rev_ff;
      row_dot_in = row_dot_ff;
      any_dot_in = any_dot_ff;
      last_col_in = last_col_ff;
      e_start_in = e_start_ff;
      e_len_in = e_len_ff;
      if (accept) begin
         if (is_dot) begin
            last_col_in = col_c;
            row_dot_in = 1'b1;
            any_dot_in = 1'b1;
            e_start_in = '0;
            e_len_in = '0;
         end else if (row_dot_ff) begin
            if (e_len_ff == '0) e_start_in = col_c;
            if (e_len_ff != sdpe_pkg::COUNT_MAX) e_len_in = e_len_ff + 1'b1;
         end
         if (end_of_row) begin
            rev_in = rev_ff ^ row_dot_next;
            row_dot_in = 1'b0;
            e_start_in = '0;
            e_len_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rev_ff <= 1'b0;
         row_dot_ff <= 1'b0;
         any_dot_ff <= 1'b0;
         last_col_ff <= '0;
         e_start_ff <= '0;
         e_len_ff <= '0;
      end else begin
         rev_ff <= rev_in;
         row_dot_ff <= row_dot_in;
         any_dot_ff <= any_dot_in;
         last_col_ff <= last_col_in;
         e_start_ff <= e_start_in;
         e_len_ff <= e_len_in;
      end
   end

   a_travel_exclusive: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !(push_data.mask[sdpe_pkg::SLOT_TRAV1] &&
                       push_data.mask[sdpe_pkg::SLOT_TRAV2]))
      else $error("both travel runs set for one item");

   a_empty_only_mid_row: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_data.mask[sdpe_pkg::SLOT_EMPTY] |->
         !push_data.mask[sdpe_pkg::SLOT_ROW] && push_data.mask[sdpe_pkg::SLOT_DOT])
      else $error("empty run flushed outside a dotted row");

endmodule

`default_nettype wire

// File: rtl/sdpe_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sdpe_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  sdpe_pkg::bundle_type  push_data,
   output logic                  full,
   input  wire                   pop,
   output logic                  not_empty,
   output sdpe_pkg::bundle_type  pop_data
);

   sdpe_pkg::bundle_type          entry_ff [sdpe_pkg::QUEUE_DEPTH];
   logic [sdpe_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [sdpe_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [sdpe_pkg::QPTR_W:0]     count_ff, count_in;

   assign full = count_ff == (sdpe_pkg::QPTR_W + 1)'(sdpe_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) wr_ptr_in = wr_ptr_ff + 1'b1;
      if (pop) rd_ptr_in = rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from an empty queue");

endmodule

`default_nettype wire

// File: rtl/sdpe_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sdpe_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   q_not_empty,
   input  sdpe_pkg::bundle_type  q_data,
   output logic                  q_pop,
   output logic                  out_valid,
   input  wire                   out_ready,
   output sdpe_pkg::result_type  out_data
);

   sdpe_pkg::bundle_type            cur_ff, cur_in;
   logic [sdpe_pkg::NUM_SLOTS-1:0]  mask_ff, mask_in;
   logic                            valid_ff, valid_in;
   sdpe_pkg::result_type            res_ff, res_in;

   logic [sdpe_pkg::NUM_SLOTS-1:0]  sel;
   logic [sdpe_pkg::NUM_SLOTS-1:0]  rest;
   logic                            emit;
   logic                            cur_done;
   sdpe_pkg::result_type            res;

   // lowest pending slot goes out first
   assign sel = mask_ff & (~mask_ff + 1'b1);
   assign rest = mask_ff & ~sel;
   assign emit = (mask_ff != '0) && (!valid_ff || out_ready);
   assign cur_done = (mask_ff == '0) || (emit && (rest == '0));
   assign q_pop = cur_done && q_not_empty;

   always_comb begin
      res = '0;
      res.last = rest == '0;
      unique case (sel)
         sdpe_pkg::SEL_TRAV1: begin
            res.kind = sdpe_pkg::KIND_TRAVEL;
            res.word = sdpe_pkg::WORD_W'(cur_ff.t1_start);
            res.count = cur_ff.trav_count;
            res.desc = !cur_ff.rev;
         end
         sdpe_pkg::SEL_ROW: begin
            res.kind = sdpe_pkg::KIND_ROW;
            res.word = {sdpe_pkg::ROW_PREFIX, cur_ff.row};
            res.count = sdpe_pkg::COUNT_W'(1);
         end
         sdpe_pkg::SEL_TRAV2: begin
            res.kind = sdpe_pkg::KIND_TRAVEL;
            res.word = sdpe_pkg::WORD_W'(cur_ff.last_col);
            res.count = cur_ff.trav_count;
            res.desc = cur_ff.rev;
         end
         sdpe_pkg::SEL_EMPTY: begin
            res.kind = sdpe_pkg::KIND_EMPTY;
            res.word = sdpe_pkg::WORD_W'(cur_ff.e_start);
            res.count = cur_ff.e_count;
            res.desc = cur_ff.rev;
         end
         sdpe_pkg::SEL_DOT: begin
            res.kind = sdpe_pkg::KIND_DOT;
            res.word = {sdpe_pkg::DOT_PREFIX, cur_ff.dot_col};
            res.count = sdpe_pkg::COUNT_W'(1);
         end
         sdpe_pkg::SEL_END: begin
            res.kind = sdpe_pkg::KIND_ROW_END;
            res.desc = cur_ff.end_desc;
         end
         default: res = '0;
      endcase
   end

   always_comb begin
      cur_in = cur_ff;
      mask_in = mask_ff;
      if (q_pop) begin
         cur_in = q_data;
         mask_in = q_data.mask;
      end else if (emit) begin
         mask_in = rest;
      end
      valid_in = emit || (valid_ff && !out_ready);
      res_in = emit ? res : res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      res_ff <= res_in;
   end

   assign out_valid = valid_ff;
   assign out_data = res_ff;

   a_pop_only_when_done: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (mask_ff == '0) || (emit && $onehot(mask_ff)))
      else $error("new item loaded while results still pending");

endmodule

`default_nettype wire

// File: rtl/serpentine_dot_path_encoder_unit.sv
// An item's first result passes the queue entry, the sequencer's item register and the output
// register. One item per cycle while each causes at most one result and rsp_tready is high; an
// item causing k results holds the sequencer until all k are sent, one result per cycle while
// rsp_tready is high. Items causing no result are not queued; a four-entry queue absorbs bursts.
// Reset (synchronous, active high): scan state cleared, queue emptied, threshold back to 224.
`timescale 1ns / 1ps
`default_nettype none

module serpentine_dot_path_encoder_unit #(
   parameter int COORD_BITS = 12
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [31:0]  req_tdata,   // pixel[7:0], column[19:8], row[31:20]
   input  wire         req_tlast,   // end_of_row
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // word[15:0], count[27:16], descending[28], zero[31:29]
   output logic [2:0]  rsp_tuser,   // kind[2:0]
   output logic        rsp_tlast,   // last
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire [2:0]   csr_paddr,
   input  wire [31:0]  csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic REG_THRESHOLD = 1'b0;

   logic [sdpe_pkg::THR_W-1:0] thr_ff, thr_in;
   logic                       csr_write;

   logic                 q_full;
   logic                 push_valid;
   sdpe_pkg::bundle_type push_data;
   logic                 q_pop;
   logic                 q_not_empty;
   sdpe_pkg::bundle_type q_data;
   sdpe_pkg::result_type result;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign thr_in = (csr_write && (csr_paddr[2] == REG_THRESHOLD))
                   ? csr_pwdata[sdpe_pkg::THR_W-1:0] : thr_ff;
   assign csr_prdata = (csr_paddr[2] == REG_THRESHOLD) ? 32'(thr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= sdpe_pkg::THR_RESET;
      else thr_ff <= thr_in;
   end

   sdpe_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .threshold(thr_ff),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .pixel(req_tdata[7:0]),
      .column(req_tdata[19:8]),
      .row(req_tdata[31:20]),
      .end_of_row(req_tlast),
      .q_full(q_full),
      .push_valid(push_valid),
      .push_data(push_data)
   );

   sdpe_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push_valid),
      .push_data(push_data),
      .full(q_full),
      .pop(q_pop),
      .not_empty(q_not_empty),
      .pop_data(q_data)
   );

   sdpe_back u_back (
      .clock(clock),
      .reset(reset),
      .q_not_empty(q_not_empty),
      .q_data(q_data),
      .q_pop(q_pop),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data(result)
   );

   assign rsp_tdata = {3'b000, result.desc, result.count, result.word};
   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.last;

endmodule

`default_nettype wire
